/* hdl/lpc_pkg.sv */
// lpc_pkg: shared types, constants and the arctangent table of the lidar
// polar-to-cartesian unit. No dependencies; used by every module in hdl/.
package lpc_pkg;

	// frame and window limits
	localparam logic [12:0] MAX_SAMPLES = 13'd4096;
	localparam logic [12:0] MAX_POINTS  = 13'd4096;

	// angles in 1/65536 degree
	localparam int ZW = 26;
	localparam logic signed [ZW-1:0] DEG90     = 26'sd5898240;
	localparam logic signed [ZW-1:0] NEG_DEG90 = -26'sd5898240;
	localparam logic signed [ZW-1:0] DEG180    = 26'sd11796480;
	localparam logic signed [ZW-1:0] DEG360    = 26'sd23592960;

	// angle accumulator and restoring reduction modulo 360 degrees
	localparam int ACC_W     = 38;
	localparam int RED_STEPS = 13;
	localparam int RED_W     = 4;
	localparam logic [ACC_W-1:0] DEG360_ACC = 38'd23592960;

	// cordic datapath
	localparam int CORDIC_STAGES = 16;
	localparam int STAGE_W       = 5;
	localparam int XW            = 36;
	localparam int GPROD_W       = 47;
	localparam logic [29:0] GAIN_Q30 = 30'd652032875;
	localparam logic signed [XW-1:0] ROUND_HALF  = 36'sd32768;
	localparam logic signed [XW-1:0] COORD_LIMIT = 36'sd131070;

	// mid queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [2:0] {
		REG_WINDOW_START  = 3'd0,
		REG_WINDOW_COUNT  = 3'd1,
		REG_START_ANGLE   = 3'd2,
		REG_ANGLE_STEP    = 3'd3,
		REG_RANGE_LOW     = 3'd4,
		REG_RANGE_HIGH    = 3'd5,
		REG_REVERSE_ORDER = 3'd6
	} lpc_reg_t;

	typedef struct packed {
		logic [11:0]        window_start;
		logic [12:0]        window_count;
		logic signed [24:0] start_angle;
		logic [24:0]        angle_step;
		logic [15:0]        range_low;
		logic [15:0]        range_high;
		logic               reverse_order;
	} lpc_cfg_t;

	// one classified point waiting for the rotation engine
	typedef struct packed {
		logic [15:0] raw;
		logic [15:0] inten;
		logic [11:0] p;
		logic [11:0] slot;
		logic        gate;
		logic        last;
	} lpc_item_t;

	// round(atan(2^-i) degrees * 65536)
	function automatic logic signed [ZW-1:0] atan_lut(input logic [STAGE_W-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/lpc_front.sv */
// lpc_front: sample counter and window / range classification.
// Depends on lpc_pkg; feeds lpc_queue with points that lie inside the window.
module lpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [15:0]       raw_range,
	input  logic [15:0]       raw_intensity,
	input  logic              frame_start,
	input  lpc_pkg::lpc_cfg_t cfg,
	input  logic              q_full,
	output logic              q_push,
	output lpc_pkg::lpc_item_t q_item
);

	logic [12:0] cnt_q;
	logic [12:0] idx;
	logic [12:0] count;
	logic [12:0] ws;
	logic [12:0] p13;
	logic [12:0] slot13;
	logic        over;
	logic        in_win;
	logic        accept;

	assign accept = push && !q_full;
	assign idx    = frame_start ? 13'd0 : cnt_q;
	assign over   = idx >= lpc_pkg::MAX_SAMPLES;
	assign count  = (cfg.window_count > lpc_pkg::MAX_POINTS) ? lpc_pkg::MAX_POINTS
	                                                         : cfg.window_count;
	assign ws     = {1'b0, cfg.window_start};
	assign p13    = idx - ws;
	assign in_win = !over && (idx >= ws) && (p13 < count);
	assign slot13 = cfg.reverse_order ? (count - 13'd1 - p13) : p13;

	assign q_push       = accept && in_win;
	assign q_item.raw   = raw_range;
	assign q_item.inten = raw_intensity;
	assign q_item.p     = p13[11:0];
	assign q_item.slot  = slot13[11:0];
	assign q_item.gate  = (raw_range >= cfg.range_low) && (raw_range <= cfg.range_high);
	assign q_item.last  = p13 == (count - 13'd1);

	// counter saturates at the frame limit until the next frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 13'd0;
		end else if (accept) begin
			cnt_q <= over ? lpc_pkg::MAX_SAMPLES : idx + 13'd1;
		end
	end

endmodule

/* hdl/lpc_queue.sv */
// lpc_queue: short fifo of classified points between front and back.
// Depends on lpc_pkg for the item type and depth.
module lpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpc_pkg::lpc_item_t push_data,
	output logic               full,
	input  logic               pop,
	output lpc_pkg::lpc_item_t pop_data,
	output logic               empty
);

	lpc_pkg::lpc_item_t        mem_q [lpc_pkg::QDEPTH];
	logic [lpc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lpc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lpc_pkg::QPTR_W:0]   cnt_q;
	logic                       do_wr;
	logic                       do_rd;

	assign full     = cnt_q == (lpc_pkg::QPTR_W+1)'(lpc_pkg::QDEPTH);
	assign empty    = cnt_q == '0;
	assign do_wr    = push && !full;
	assign do_rd    = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/lpc_back.sv */
// lpc_back: angle formation, reduction modulo 360 degrees, iterative cordic
// rotation and the result register. Depends on lpc_pkg.
module lpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lpc_pkg::lpc_cfg_t  cfg,
	input  logic               q_empty,
	input  lpc_pkg::lpc_item_t q_item,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [17:0] x_mm,
	output logic signed [17:0] y_mm,
	output logic [15:0]        point_intensity,
	output logic [11:0]        point_index,
	output logic               in_range,
	output logic               last_point
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_RED  = 6'b000100,
		ST_FOLD = 6'b001000,
		ST_ROT  = 6'b010000,
		ST_OUT  = 6'b100000
	} back_state_t;

	back_state_t                      state_q;
	lpc_pkg::lpc_item_t               item_q;
	logic [lpc_pkg::ACC_W-1:0]        acc_q;
	logic [lpc_pkg::GPROD_W-1:0]      gprod_q;
	logic [lpc_pkg::RED_W-1:0]        k_q;
	logic [lpc_pkg::STAGE_W-1:0]      i_q;
	logic signed [lpc_pkg::XW-1:0]    x_q;
	logic signed [lpc_pkg::XW-1:0]    y_q;
	logic signed [lpc_pkg::ZW-1:0]    z_q;
	logic                             flip_q;
	logic                             out_valid_q;
	logic signed [17:0]               x_out_q;
	logic signed [17:0]               y_out_q;
	logic [15:0]                      inten_out_q;
	logic [11:0]                      index_out_q;
	logic                             gate_out_q;
	logic                             last_out_q;

	// angle setup
	logic signed [lpc_pkg::ZW-1:0]    start_ext;
	logic signed [lpc_pkg::ZW-1:0]    start_adj;
	logic [36:0]                      step_prod;
	logic [lpc_pkg::GPROD_W-1:0]      gain_prod;
	logic [lpc_pkg::ACC_W-1:0]        mod_step;
	// fold
	logic signed [lpc_pkg::ZW-1:0]    a_raw;
	logic signed [lpc_pkg::ZW-1:0]    a_wrap;
	logic signed [lpc_pkg::ZW-1:0]    z_init;
	logic                             flip_init;
	logic [lpc_pkg::GPROD_W-1:0]      gprod_rnd;
	// rotation
	logic signed [lpc_pkg::XW-1:0]    dx;
	logic signed [lpc_pkg::XW-1:0]    dy;
	logic signed [lpc_pkg::ZW-1:0]    atan_i;
	// output rounding
	logic signed [lpc_pkg::XW-1:0]    xr;
	logic signed [lpc_pkg::XW-1:0]    yr;
	logic signed [lpc_pkg::XW-1:0]    xn;
	logic signed [lpc_pkg::XW-1:0]    yn;
	logic signed [lpc_pkg::XW-1:0]    xc;
	logic signed [lpc_pkg::XW-1:0]    yc;
	logic                             load_out;

	assign start_ext = {cfg.start_angle[24], cfg.start_angle};
	assign start_adj = start_ext[lpc_pkg::ZW-1] ? start_ext + lpc_pkg::DEG360 : start_ext;
	assign step_prod = 37'(cfg.angle_step) * 37'(item_q.p);
	assign gain_prod = lpc_pkg::GPROD_W'({item_q.raw, 1'b0}) *
	                   lpc_pkg::GPROD_W'(lpc_pkg::GAIN_Q30);
	assign mod_step  = lpc_pkg::DEG360_ACC << k_q;

	always_comb begin
		a_raw  = $signed(acc_q[lpc_pkg::ZW-1:0]);
		a_wrap = (a_raw >= lpc_pkg::DEG180) ? a_raw - lpc_pkg::DEG360 : a_raw;
		if (a_wrap > lpc_pkg::DEG90) begin
			z_init    = a_wrap - lpc_pkg::DEG180;
			flip_init = 1'b1;
		end else if (a_wrap < lpc_pkg::NEG_DEG90) begin
			z_init    = a_wrap + lpc_pkg::DEG180;
			flip_init = 1'b1;
		end else begin
			z_init    = a_wrap;
			flip_init = 1'b0;
		end
	end

	assign gprod_rnd = gprod_q + lpc_pkg::GPROD_W'(8192);
	assign dx        = y_q >>> i_q;
	assign dy        = x_q >>> i_q;
	assign atan_i    = lpc_pkg::atan_lut(i_q);

	always_comb begin
		xr = (x_q + lpc_pkg::ROUND_HALF) >>> 16;
		yr = (y_q + lpc_pkg::ROUND_HALF) >>> 16;
		xn = flip_q ? -xr : xr;
		yn = flip_q ? -yr : yr;
		if (xn > lpc_pkg::COORD_LIMIT) begin
			xc = lpc_pkg::COORD_LIMIT;
		end else if (xn < -lpc_pkg::COORD_LIMIT) begin
			xc = -lpc_pkg::COORD_LIMIT;
		end else begin
			xc = xn;
		end
		if (yn > lpc_pkg::COORD_LIMIT) begin
			yc = lpc_pkg::COORD_LIMIT;
		end else if (yn < -lpc_pkg::COORD_LIMIT) begin
			yc = -lpc_pkg::COORD_LIMIT;
		end else begin
			yc = yn;
		end
	end

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_item.gate ? ST_MUL : ST_OUT;
					end
				end
				ST_MUL: begin
					k_q     <= lpc_pkg::RED_W'(lpc_pkg::RED_STEPS - 1);
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (k_q == '0) begin
						state_q <= ST_FOLD;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_FOLD: begin
					i_q     <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (i_q == lpc_pkg::STAGE_W'(lpc_pkg::CORDIC_STAGES - 1)) begin
						state_q <= ST_OUT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		case (state_q)
			ST_MUL: begin
				acc_q   <= lpc_pkg::ACC_W'(step_prod) +
				           lpc_pkg::ACC_W'($unsigned(start_adj));
				gprod_q <= gain_prod;
			end
			ST_RED: begin
				// restoring step, remainder stays below 360 degrees shifted by k
				if (acc_q >= mod_step) begin
					acc_q <= acc_q - mod_step;
				end
			end
			ST_FOLD: begin
				x_q    <= $signed(lpc_pkg::XW'(gprod_rnd >> 14));
				y_q    <= '0;
				z_q    <= z_init;
				flip_q <= flip_init;
			end
			ST_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_i;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			x_out_q     <= item_q.gate ? xc[17:0] : 18'sd0;
			y_out_q     <= item_q.gate ? yc[17:0] : 18'sd0;
			inten_out_q <= item_q.gate ? item_q.inten : 16'd0;
			index_out_q <= item_q.slot;
			gate_out_q  <= item_q.gate;
			last_out_q  <= item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty           = !out_valid_q;
	assign x_mm            = x_out_q;
	assign y_mm            = y_out_q;
	assign point_intensity = inten_out_q;
	assign point_index     = index_out_q;
	assign in_range        = gate_out_q;
	assign last_point      = last_out_q;

endmodule

/* hdl/lidar_polar_to_cartesian_unit.sv */
// lidar_polar_to_cartesian_unit: top level with configuration registers,
// front classifier, mid queue and cordic back end. Depends on lpc_pkg,
// lpc_front, lpc_queue and lpc_back.
//
//  channel   direction  handshake              payload
//  samples   in         push / full            raw_range, raw_intensity, frame_start
//  points    out        pop / empty            x_mm, y_mm, point_intensity,
//                                              point_index, in_range, last_point
//  config    in/out     psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// samples are taken one per cycle while the four-entry mid queue has room;
// samples outside the window leave no trace past the counter.
// an in-range point passes the back end as dequeue, multiply, 13 restoring steps
// reducing the angle modulo 360 degrees, fold, 16 cordic iterations and output
// load; a gated-out point goes from the dequeue straight to the output load.
// reset clears the counter, queue pointers, engine state and result valid.
// a held result stalls only the back end; the front stops once the queue is full.
module lidar_polar_to_cartesian_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        raw_range,
	input  logic [15:0]        raw_intensity,
	input  logic               frame_start,
	output logic               empty,
	input  logic               pop,
	output logic signed [17:0] x_mm,
	output logic signed [17:0] y_mm,
	output logic [15:0]        point_intensity,
	output logic [11:0]        point_index,
	output logic               in_range,
	output logic               last_point,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	lpc_pkg::lpc_cfg_t  cfg_q;
	lpc_pkg::lpc_reg_t  reg_sel;
	lpc_pkg::lpc_item_t f_item;
	lpc_pkg::lpc_item_t q_head;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = lpc_pkg::lpc_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start  <= 12'd0;
			cfg_q.window_count  <= 13'd4096;
			cfg_q.start_angle   <= -25'sd8847360;
			cfg_q.angle_step    <= 25'd4320;
			cfg_q.range_low     <= 16'd25;
			cfg_q.range_high    <= 16'd15000;
			cfg_q.reverse_order <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_sel)
				lpc_pkg::REG_WINDOW_START:  cfg_q.window_start  <= pwdata[11:0];
				lpc_pkg::REG_WINDOW_COUNT:  cfg_q.window_count  <= pwdata[12:0];
				lpc_pkg::REG_START_ANGLE:   cfg_q.start_angle   <= $signed(pwdata[24:0]);
				lpc_pkg::REG_ANGLE_STEP:    cfg_q.angle_step    <= pwdata[24:0];
				lpc_pkg::REG_RANGE_LOW:     cfg_q.range_low     <= pwdata[15:0];
				lpc_pkg::REG_RANGE_HIGH:    cfg_q.range_high    <= pwdata[15:0];
				lpc_pkg::REG_REVERSE_ORDER: cfg_q.reverse_order <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lpc_pkg::REG_WINDOW_START:  prdata = {20'd0, cfg_q.window_start};
			lpc_pkg::REG_WINDOW_COUNT:  prdata = {19'd0, cfg_q.window_count};
			lpc_pkg::REG_START_ANGLE:   prdata = {7'd0, cfg_q.start_angle};
			lpc_pkg::REG_ANGLE_STEP:    prdata = {7'd0, cfg_q.angle_step};
			lpc_pkg::REG_RANGE_LOW:     prdata = {16'd0, cfg_q.range_low};
			lpc_pkg::REG_RANGE_HIGH:    prdata = {16'd0, cfg_q.range_high};
			lpc_pkg::REG_REVERSE_ORDER: prdata = {31'd0, cfg_q.reverse_order};
			default:                    prdata = 32'd0;
		endcase
	end

	assign full = q_full;

	lpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.raw_range     (raw_range),
		.raw_intensity (raw_intensity),
		.frame_start   (frame_start),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (f_item)
	);

	lpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	lpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_item          (q_head),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.x_mm            (x_mm),
		.y_mm            (y_mm),
		.point_intensity (point_intensity),
		.point_index     (point_index),
		.in_range        (in_range),
		.last_point      (last_point)
	);

	// a point handed to the queue must be visible there on the next cycle
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("point lost between front and queue");

	// gated-out points carry no coordinates and no intensity
	a_gate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !in_range) |-> (x_mm == 18'sd0 && y_mm == 18'sd0 &&
		point_intensity == 16'd0))
		else $error("gated-out point carries data");

	// coordinates stay inside the clamp limits
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (x_mm <= 18'sd131070 && x_mm >= -18'sd131070 &&
		y_mm <= 18'sd131070 && y_mm >= -18'sd131070))
		else $error("coordinate beyond clamp limit");

endmodule
